[rtl/fcr_pkg.sv]
// Shared types and constants for the framed command receiver.
// No dependencies; imported by fcr_parser and framed_command_receiver.
`default_nettype none

package fcr_pkg;

  localparam int unsigned FRAME_BYTES   = 6;
  localparam int unsigned PAYLOAD_LEN   = FRAME_BYTES - 2;
  localparam int unsigned POS_W         = $clog2(PAYLOAD_LEN);

  localparam logic [7:0]  HDR_FIRST     = 8'hCC;
  localparam logic [7:0]  HDR_SECOND    = 8'h33;
  localparam logic [7:0]  MODE_MAX      = 8'd2;
  localparam logic [15:0] CMD_MAX       = 16'd4095;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [11:0] HELD_CMD_RESET = 12'd2048;

  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_LINE_ERR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REJ_NONE   = 2'd0,
    REJ_CHKSUM = 2'd1,
    REJ_MODE   = 2'd2,
    REJ_CMD    = 2'd3
  } reason_t;

  typedef enum logic [1:0] {
    HUNT_FIRST  = 2'd0,
    HUNT_SECOND = 2'd1,
    COLLECT     = 2'd2
  } hunt_t;

  typedef struct packed {
    logic        done;
    logic        valid;
    reason_t     reason;
    logic [1:0]  mode;
    logic [11:0] command;
  } frame_res_t;

endpackage

`default_nettype wire

[rtl/fcr_parser.sv]
// Header hunt, payload collection and frame checks for the receiver.
// Depends on fcr_pkg.
`default_nettype none

module fcr_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire fcr_pkg::cmd_t      cmd,
  input  wire logic [7:0]         rx_byte,
  output fcr_pkg::frame_res_t     res
);
  import fcr_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_LEN - 1);

  hunt_t            state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       payload_r [PAYLOAD_LEN-1];
  logic [7:0]       chk;
  logic [15:0]      cmd_word;
  logic             store;

  assign chk      = payload_r[0] ^ payload_r[1] ^ payload_r[2];
  assign cmd_word = {payload_r[1], payload_r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HUNT_FIRST;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      payload_r[pos_r] <= rx_byte;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    store       = 1'b0;
    res         = '0;
    res.reason  = REJ_NONE;
    if (en) begin
      unique case (cmd)
        CMD_BYTE: begin
          unique case (state_r)
            HUNT_FIRST: begin
              if (rx_byte == HDR_FIRST) state_nxt = HUNT_SECOND;
            end
            HUNT_SECOND: begin
              if (rx_byte == HDR_SECOND) begin
                pos_nxt   = '0;
                state_nxt = COLLECT;
              end else if (rx_byte != HDR_FIRST) begin
                state_nxt = HUNT_FIRST;
              end
            end
            COLLECT: begin
              if (pos_r == POS_LAST) begin
                res.done = 1'b1;
                priority if (chk != rx_byte) begin
                  res.reason = REJ_CHKSUM;
                end else if (payload_r[0] > MODE_MAX) begin
                  res.reason = REJ_MODE;
                end else if (cmd_word > CMD_MAX) begin
                  res.reason = REJ_CMD;
                end else begin
                  res.valid  = 1'b1;
                end
                res.mode    = payload_r[0][1:0];
                res.command = cmd_word[11:0];
                pos_nxt     = '0;
                state_nxt   = HUNT_FIRST;
              end else begin
                store   = 1'b1;
                pos_nxt = pos_r + 1'b1;
              end
            end
            default: begin
              pos_nxt   = '0;
              state_nxt = HUNT_FIRST;
            end
          endcase
        end
        CMD_LINE_ERR: begin
          pos_nxt   = '0;
          state_nxt = HUNT_FIRST;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/framed_command_receiver.sv]
// Framed command receiver top level: link timer, held command, counters, output word.
// Depends on fcr_pkg and fcr_parser.
//
// Usage:
//   in_*  : one word per serial event; in_tuser is the event kind (0 byte,
//           1 millisecond tick, 2 line error, 3 ignored), in_tdata the byte.
//   out_* : exactly one result word per input word, in order. out_tlast marks
//           the byte that completed a six-byte frame (0xCC 0x33 mode cmd_hi
//           cmd_lo xor); out_tuser carries the frame verdict; out_tdata the
//           held mode and command, link status and the two frame counters.
//   cfg_* : writes the 16-bit link timeout in ticks; always ready, write
//           only while no result is outstanding.
// out_tvalid rises in the cycle after an input word is accepted. One word is taken
// every cycle; the single output register stalls intake only while it holds
// a word that the receiver has not taken (in_tready = !out_tvalid | out_tready).
// Reset (synchronous, active low) restarts the header hunt, clears counters,
// timer and link status, sets the held command to 2048 and the timeout to 500.
`default_nettype none

module framed_command_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [1:0] mode_out, [13:2] command_value,
                                       // [14] link_alive, [46:15] valid_frames,
                                       // [78:47] invalid_frames, [79] zero
  output logic [2:0]       out_tuser,  // [0] frame_valid, [2:1] reject_reason
  output logic             out_tlast,  // frame_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import fcr_pkg::*;

  logic        acc;
  cmd_t        cmd;
  frame_res_t  res;

  logic [15:0] timeout_r;
  logic [1:0]  mode_r, mode_nxt;
  logic [11:0] held_cmd_r, held_cmd_nxt;
  logic        seen_r, seen_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic        alive_nxt;

  logic        out_valid_r;
  logic [79:0] out_data_r;
  logic [2:0]  out_user_r;
  logic        out_last_r;

  assign cmd       = cmd_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  fcr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (acc),
    .cmd     (cmd),
    .rx_byte (in_tdata),
    .res     (res)
  );

  always_comb begin
    mode_nxt     = mode_r;
    held_cmd_nxt = held_cmd_r;
    seen_nxt     = seen_r;
    ticks_nxt    = ticks_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    if (acc) begin
      if (res.done) begin
        if (res.valid) begin
          mode_nxt     = res.mode;
          held_cmd_nxt = res.command;
          seen_nxt     = 1'b1;
          ticks_nxt    = '0;
          good_nxt     = good_r + 32'd1;
        end else begin
          bad_nxt      = bad_r + 32'd1;
        end
      end
      if (cmd == CMD_TICK && ticks_r != '1) begin
        ticks_nxt = ticks_r + 16'd1;
      end
    end
    alive_nxt = seen_nxt && (ticks_nxt <= timeout_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      mode_r      <= '0;
      held_cmd_r  <= HELD_CMD_RESET;
      seen_r      <= 1'b0;
      ticks_r     <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
      mode_r     <= mode_nxt;
      held_cmd_r <= held_cmd_nxt;
      seen_r     <= seen_nxt;
      ticks_r    <= ticks_nxt;
      good_r     <= good_nxt;
      bad_r      <= bad_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= {1'b0, bad_nxt, good_nxt, alive_nxt, held_cmd_nxt, mode_nxt};
      out_user_r <= {res.reason, res.valid};
      out_last_r <= res.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // a passing frame is always a completed one with no reject code
  a_valid_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[0] |-> out_last_r && out_user_r[2:1] == REJ_NONE)
    else $error("frame_valid without frame_done");

  // a rejected frame carries a reason
  a_reject_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r && !out_user_r[0] |-> out_user_r[2:1] != REJ_NONE)
    else $error("rejected frame without reason");

  // good frame bumps the counter and restarts the timer
  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.valid |=> good_r == $past(good_r) + 32'd1 && ticks_r == '0 && seen_r)
    else $error("valid frame not counted");

  // link status never reported before a valid frame
  a_alive_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[14] |-> seen_r)
    else $error("link alive before any valid frame");

endmodule

`default_nettype wire

[tb/fcr_status_checker.sv]
// Status checker for framed_command_receiver: watches the input, config and result
// channels, keeps its own copy of the receiver state and compares every result word.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_status_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [79:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               error_count,
  output int               pending_words,
  output int               words_checked,
  output int               frames_passed,
  output int               frames_rejected
);
  import fcr_pkg::*;

  typedef struct packed {
    logic        done;
    logic        valid;
    reason_t     reason;
    logic [1:0]  mode;
    logic [11:0] command;
    logic        alive;
    logic [31:0] good;
    logic [31:0] bad;
  } rx_status_t;

  rx_status_t  status_q[$];

  hunt_t       hunt;
  logic [2:0]  pay_idx;
  logic [7:0]  payload [4];
  logic [1:0]  held_mode;
  logic [11:0] held_cmd;
  logic        seen_good;
  logic [15:0] ticks;
  logic [31:0] good_cnt;
  logic [31:0] bad_cnt;
  logic [15:0] timeout_ticks;

  function automatic reason_t judge_frame(input logic [7:0] m, input logic [7:0] hi,
                                          input logic [7:0] lo, input logic [7:0] chk);
    if ((m ^ hi ^ lo) != chk) return REJ_CHKSUM;
    if (m > MODE_MAX) return REJ_MODE;
    if ({hi, lo} > CMD_MAX) return REJ_CMD;
    return REJ_NONE;
  endfunction

  task automatic apply_rx_event(input logic [1:0] kind, input logic [7:0] rx,
                                output rx_status_t st);
    reason_t why;
    logic    done;
    done = 1'b0;
    why  = REJ_NONE;
    case (kind)
      CMD_BYTE: begin
        case (hunt)
          HUNT_FIRST: begin
            if (rx == HDR_FIRST) hunt = HUNT_SECOND;
          end
          HUNT_SECOND: begin
            if (rx == HDR_SECOND) begin
              pay_idx = '0;
              hunt    = COLLECT;
            end else if (rx != HDR_FIRST) begin
              hunt = HUNT_FIRST;
            end
          end
          COLLECT: begin
            payload[pay_idx[1:0]] = rx;
            pay_idx = pay_idx + 3'd1;
            if (pay_idx >= PAYLOAD_LEN) begin
              done = 1'b1;
              why  = judge_frame(payload[0], payload[1], payload[2], payload[3]);
              if (why == REJ_NONE) begin
                held_mode = payload[0][1:0];
                held_cmd  = {payload[1][3:0], payload[2]};
                ticks     = '0;
                seen_good = 1'b1;
                good_cnt  = good_cnt + 32'd1;
              end else begin
                bad_cnt = bad_cnt + 32'd1;
              end
              pay_idx = '0;
              hunt    = HUNT_FIRST;
            end
          end
          default: begin
            pay_idx = '0;
            hunt    = HUNT_FIRST;
          end
        endcase
      end
      CMD_TICK: begin
        if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
      end
      CMD_LINE_ERR: begin
        pay_idx = '0;
        hunt    = HUNT_FIRST;
      end
      default: ;
    endcase
    st.done    = done;
    st.valid   = done && (why == REJ_NONE);
    st.reason  = why;
    st.mode    = held_mode;
    st.command = held_cmd;
    st.alive   = seen_good && (ticks <= timeout_ticks);
    st.good    = good_cnt;
    st.bad     = bad_cnt;
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rx_status_t want;
    rx_status_t got;
    if (!rst_n) begin
      timeout_ticks = TIMEOUT_RESET;
      hunt          = HUNT_FIRST;
      pay_idx       = '0;
      held_mode     = '0;
      held_cmd      = HELD_CMD_RESET;
      seen_good     = 1'b0;
      ticks         = '0;
      good_cnt      = '0;
      bad_cnt       = '0;
      status_q.delete();
      pending_words = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.done    = out_tlast;
        got.valid   = out_tuser[0];
        got.reason  = reason_t'(out_tuser[2:1]);
        got.mode    = out_tdata[1:0];
        got.command = out_tdata[13:2];
        got.alive   = out_tdata[14];
        got.good    = out_tdata[46:15];
        got.bad     = out_tdata[78:47];
        words_checked++;
        if (status_q.size() == 0) begin
          error_count++;
          $error("result word with no pending expectation");
        end else begin
          want = status_q.pop_front();
          report_field("frame_done", want.done, got.done);
          report_field("frame_valid", want.valid, got.valid);
          report_field("reject_reason", want.reason, got.reason);
          report_field("mode_out", want.mode, got.mode);
          report_field("command_value", want.command, got.command);
          report_field("link_alive", want.alive, got.alive);
          report_field("valid_frames", want.good, got.good);
          report_field("invalid_frames", want.bad, got.bad);
          report_field("tdata_pad", '0, out_tdata[79]);
        end
      end
      if (cfg_valid && cfg_ready) timeout_ticks = cfg_data;
      if (in_tvalid && in_tready) begin
        apply_rx_event(in_tuser, in_tdata, want);
        status_q.push_back(want);
        if (want.done && want.valid) frames_passed++;
        if (want.done && !want.valid) frames_rejected++;
      end
      pending_words = status_q.size();
    end
  end

endmodule

[tb/tb_framed_command_receiver.sv]
// Top-level testbench for framed_command_receiver: drives bytes, ticks, line errors
// and timeout writes with random gaps and stalls; fcr_status_checker does the checking.
// Depends on fcr_pkg, framed_command_receiver and fcr_status_checker.
`timescale 1ns / 1ps

module tb_framed_command_receiver;
  import fcr_pkg::*;

  localparam logic [1:0] KIND_RESERVED  = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         PHASE_WORDS    = 115;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [15:0] cfg_data   = '0;

  wire logic        in_tready;
  wire logic        out_tvalid;
  wire logic [79:0] out_tdata;
  wire logic [2:0]  out_tuser;
  wire logic        out_tlast;
  wire logic        cfg_ready;

  int error_count;
  int pending_words;
  int words_checked;
  int frames_passed;
  int frames_rejected;

  bit steady      = 1'b0;
  int stall_left  = 0;
  int idle_cycles = 0;
  int sent_words  = 0;
  int settings_used = 0;

  framed_command_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  fcr_status_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .pending_words   (pending_words),
    .words_checked   (words_checked),
    .frames_passed   (frames_passed),
    .frames_rejected (frames_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver backpressure: mostly short stalls, an occasional long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [7:0] rx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= rx;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if (kind != KIND_RESERVED) sent_words++;
  endtask

  // frame bytes may have ticks slipped in between them
  task automatic frame_byte(input logic [7:0] b);
    if ($urandom_range(0, 11) == 0) send_word(CMD_TICK, 8'($urandom_range(0, 255)));
    send_word(CMD_BYTE, b);
  endtask

  task automatic send_frame(input logic [7:0] m, input logic [7:0] hi, input logic [7:0] lo,
                            input bit bad_chk);
    logic [7:0] chk;
    chk = m ^ hi ^ lo;
    if (bad_chk) chk = chk ^ (8'h01 << $urandom_range(0, 7));
    frame_byte(HDR_FIRST);
    frame_byte(HDR_SECOND);
    frame_byte(m);
    frame_byte(hi);
    frame_byte(lo);
    frame_byte(chk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic random_traffic(input int quota);
    int         start;
    int         r;
    logic [7:0] m;
    logic [7:0] hi;
    start = sent_words;
    while (sent_words - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(3, 255));
        hi = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) frame_byte(HDR_FIRST);
        send_frame(m, hi, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (r < 70) begin
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5))
          send_word(CMD_TICK, 8'($urandom_range(0, 255)));
      end else if (r < 82) begin
        if ($urandom_range(0, 3) == 0)
          send_word(CMD_BYTE, $urandom_range(0, 1) ? HDR_FIRST : HDR_SECOND);
        else
          send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 92) begin
        // frame cut short by a line error
        frame_byte(HDR_FIRST);
        frame_byte(HDR_SECOND);
        repeat ($urandom_range(0, 3)) frame_byte(8'($urandom_range(0, 255)));
        send_word(CMD_LINE_ERR, 8'($urandom_range(0, 255)));
      end else if (r < 97) begin
        send_word(CMD_LINE_ERR, 8'($urandom_range(0, 255)));
      end else begin
        send_word(KIND_RESERVED, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [15:0] timeouts [6];
    timeouts = '{16'd0, 16'd3, 16'hFFFE, 16'd20, 16'hFFFF, 16'd1};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: link down before any frame, ignored kind, repeated header byte,
    // field extremes, each reject reason, and a line error mid-frame
    send_word(CMD_TICK, 8'hFF);
    send_word(KIND_RESERVED, 8'hA5);
    frame_byte(HDR_FIRST);
    send_frame(8'd2, 8'h0F, 8'hFF, 1'b0);
    send_frame(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_frame(8'd1, 8'h10, 8'h00, 1'b0);
    send_frame(8'd0, 8'h00, 8'h00, 1'b1);
    frame_byte(HDR_FIRST);
    frame_byte(HDR_SECOND);
    frame_byte(8'd1);
    send_word(CMD_LINE_ERR, 8'h00);

    for (int i = 0; i < 6; i++) begin
      drain_results();
      write_timeout(timeouts[i]);
      steady = (i == 3);
      random_traffic(PHASE_WORDS);
    end

    drain_results();
    repeat (5) @(posedge clk);

    $display("Run: %0d result words checked, %0d frames accepted, %0d frames rejected",
             words_checked, frames_passed, frames_rejected);
    $display("Run: %0d timeout settings incl. 0, 65534 and 65535, one phase back to back",
             settings_used);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
